// ----- design/open_addressing_hash_insert_defines.svh -----
// assertion macros for the open addressing hash insert block
// used by the top level only; no other dependencies
`ifndef OPEN_ADDRESSING_HASH_INSERT_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_INSERT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OAHI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define OAHI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/oahi_pkg.sv -----
// shared constants, types and helpers of the hash insert block
// no dependencies
package oahi_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = SLOT_W + 1;
    localparam int BANK_AW     = SLOT_W + 1;
    localparam int PROBE_W     = SIZE_W + 1;
    localparam int HASH_W      = 32;
    localparam int KEY_W       = 8;
    localparam int COLL_W      = 10;
    localparam int FILL_W      = 8;
    localparam int ENTRY_W     = HASH_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEP    = 4;
    localparam int DIV_CYC     = HASH_W / DIV_STEP;
    localparam int DIVCNT_W    = $clog2(DIV_CYC);

    localparam logic [HASH_W-1:0] HASH_START  = 32'd5381;
    localparam logic [SIZE_W-1:0] RESET_SLOTS = 11'd64;
    localparam logic [FILL_W-1:0] RESET_FILL  = 8'd192;
    localparam logic [SIZE_W-1:0] DEPTH_SIZE  = SIZE_W'(TABLE_DEPTH);
    localparam logic [COLL_W-1:0] COLL_MAX    = {COLL_W{1'b1}};

    // register indexes
    localparam logic REG_SLOTS = 1'b0;
    localparam logic REG_FILL  = 1'b1;

    typedef struct packed {
        logic              reinit;
        logic [SIZE_W-1:0] init_slots;
        logic [FILL_W-1:0] max_fill;
    } t_cfg;

    typedef struct packed {
        logic clearing;
        logic growing;
    } t_stat;

    function automatic logic [HASH_W-1:0] magnitude(input logic [HASH_W-1:0] x);
        return x[HASH_W-1] ? (~x + HASH_W'(1)) : x;
    endfunction

endpackage

// ----- design/open_addressing_hash_insert.sv -----
// a key byte is taken when i_valid and o_ready are both high; a last byte's hash
// goes through the four-bit-per-cycle remainder unit, then a read and a check per
// probed slot; a growth adds a clear of the new bank plus a read and check per old
// slot and a probe run per stored key; a two-entry hash queue lets bytes keep
// arriving meanwhile until it is full; after reset, and after each initial_slots
// write, a clear of bank 0 runs with o_ready low; reset is synchronous, active low
`include "open_addressing_hash_insert_defines.svh"
module open_addressing_hash_insert (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [oahi_pkg::KEY_W-1:0] i_key_byte,
    input  logic                              i_last_byte,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [oahi_pkg::COLL_W-1:0]       o_collision_count,
    output logic [oahi_pkg::SLOT_W-1:0]       o_slot_index,
    output logic                              o_grew,
    output logic                              o_full_flag,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [oahi_pkg::SIZE_W-1:0] r_init_slots;
    logic [oahi_pkg::FILL_W-1:0] r_fill;
    logic [oahi_pkg::SIZE_W-1:0] wr_slots;
    logic                        cfg_wr;
    oahi_pkg::t_cfg              cfg;
    oahi_pkg::t_stat             stat;

    logic                        q_push;
    logic [oahi_pkg::HASH_W-1:0] q_push_hash;
    logic                        q_pop;
    logic [oahi_pkg::HASH_W-1:0] q_data;
    logic                        q_full;
    logic                        q_empty;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // zero reads as one slot, anything past the depth as the depth
    always_comb begin
        wr_slots = pwdata[oahi_pkg::SIZE_W-1:0];
        if (wr_slots == '0) begin
            wr_slots = oahi_pkg::SIZE_W'(1);
        end else if (wr_slots > oahi_pkg::DEPTH_SIZE) begin
            wr_slots = oahi_pkg::DEPTH_SIZE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_slots <= oahi_pkg::RESET_SLOTS;
            r_fill       <= oahi_pkg::RESET_FILL;
        end else if (cfg_wr) begin
            if (paddr[2] == oahi_pkg::REG_SLOTS) begin
                r_init_slots <= wr_slots;
            end else begin
                r_fill <= pwdata[oahi_pkg::FILL_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == oahi_pkg::REG_FILL) ? 32'(r_fill) : 32'(r_init_slots);

    assign cfg.reinit     = cfg_wr && (paddr[2] == oahi_pkg::REG_SLOTS);
    assign cfg.init_slots = wr_slots;
    assign cfg.max_fill   = r_fill;

    oahi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_key_byte  (i_key_byte),
        .i_last_byte (i_last_byte),
        .i_stat      (stat),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_hash (q_push_hash)
    );

    oahi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_push_hash),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    oahi_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .o_stat            (stat),
        .i_q_empty         (q_empty),
        .i_q_data          (q_data),
        .o_q_pop           (q_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_collision_count (o_collision_count),
        .o_slot_index      (o_slot_index),
        .o_grew            (o_grew),
        .o_full_flag       (o_full_flag)
    );

    `OAHI_ASSERT_IMP(a_no_transfer_in_clear, i_clk, i_rst_n, stat.clearing, !o_ready, "input taken during clear")
    `OAHI_ASSERT_IMP(a_queue_no_overflow, i_clk, i_rst_n, q_full, !q_push, "hash queue overflow")
    `OAHI_ASSERT_IMP(a_grew_not_full, i_clk, i_rst_n, o_valid && o_grew, !o_full_flag, "grew with full")
    `OAHI_ASSERT_NXT(a_reinit_clears, i_clk, i_rst_n, cfg.reinit, stat.clearing && !stat.growing, "no clear")

endmodule

// ----- design/oahi_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
module oahi_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/oahi_fifo.sv -----
// short hash queue between front and back
// depends on oahi_pkg
module oahi_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [oahi_pkg::HASH_W-1:0] i_data,
    input  logic                       i_pop,
    output logic [oahi_pkg::HASH_W-1:0] o_data,
    output logic                       o_full,
    output logic                       o_empty
);

    logic [oahi_pkg::HASH_W-1:0] r_mem [oahi_pkg::QUEUE_DEPTH];
    logic [oahi_pkg::QPTR_W-1:0] r_wptr;
    logic [oahi_pkg::QPTR_W-1:0] r_rptr;
    logic [oahi_pkg::QPTR_W:0]   r_count;

    assign o_full  = (r_count == (oahi_pkg::QPTR_W + 1)'(oahi_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + oahi_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + oahi_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (oahi_pkg::QPTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (oahi_pkg::QPTR_W + 1)'(1);
            end
        end
    end

endmodule

// ----- design/oahi_front.sv -----
// front end: accepts key bytes and keeps the running djb2 hash
// depends on oahi_pkg; pushes finished hashes into oahi_fifo
module oahi_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [oahi_pkg::KEY_W-1:0] i_key_byte,
    input  logic                        i_last_byte,
    input  oahi_pkg::t_stat             i_stat,
    input  logic                        i_q_full,
    output logic                        o_push,
    output logic [oahi_pkg::HASH_W-1:0] o_push_hash
);

    logic [oahi_pkg::HASH_W-1:0] r_hash;
    logic [oahi_pkg::HASH_W-1:0] n_hash;
    logic                        accept;

    assign o_ready = !i_q_full && !i_stat.clearing;
    assign accept  = i_valid && o_ready;

    // times 33 plus the sign-extended byte
    assign n_hash = (r_hash << 5) + r_hash
                  + {{(oahi_pkg::HASH_W - oahi_pkg::KEY_W){i_key_byte[oahi_pkg::KEY_W-1]}},
                     i_key_byte};

    assign o_push      = accept && i_last_byte;
    assign o_push_hash = n_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= oahi_pkg::HASH_START;
        end else if (accept) begin
            r_hash <= i_last_byte ? oahi_pkg::HASH_START : n_hash;
        end
    end

endmodule

// ----- design/oahi_mod.sv -----
// remainder unit: 32-bit magnitude mod table size, four bits per cycle
// depends on oahi_pkg
module oahi_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [oahi_pkg::HASH_W-1:0] i_dividend,
    input  logic [oahi_pkg::SIZE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [oahi_pkg::SIZE_W-1:0] o_rem
);

    logic                          r_busy;
    logic                          r_done;
    logic [oahi_pkg::DIVCNT_W-1:0] r_cnt;
    logic [oahi_pkg::HASH_W-1:0]   r_dvd;
    logic [oahi_pkg::SIZE_W-1:0]   r_d;
    logic [oahi_pkg::SIZE_W-1:0]   r_rem;
    logic [oahi_pkg::SIZE_W-1:0]   n_rem;

    // restoring steps, remainder stays below the divisor
    always_comb begin : step
        logic [oahi_pkg::SIZE_W:0] t;
        n_rem = r_rem;
        for (int k = 0; k < oahi_pkg::DIV_STEP; k++) begin
            t = {n_rem, r_dvd[oahi_pkg::HASH_W-1-k]};
            if (t >= {1'b0, r_d}) begin
                t = t - {1'b0, r_d};
            end
            n_rem = t[oahi_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << oahi_pkg::DIV_STEP;
            r_rem <= n_rem;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + oahi_pkg::DIVCNT_W'(1);
                if (r_cnt == oahi_pkg::DIVCNT_W'(oahi_pkg::DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- design/oahi_back.sv -----
// back end: probes the table, inserts, grows and rehashes, holds the result register
// depends on oahi_pkg, oahi_ram, oahi_mod
module oahi_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  oahi_pkg::t_cfg              i_cfg,
    output oahi_pkg::t_stat             o_stat,
    input  logic                        i_q_empty,
    input  logic [oahi_pkg::HASH_W-1:0] i_q_data,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [oahi_pkg::COLL_W-1:0] o_collision_count,
    output logic [oahi_pkg::SLOT_W-1:0] o_slot_index,
    output logic                        o_grew,
    output logic                        o_full_flag
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DIV, S_RD, S_CHK, S_GCHK, S_SCAN_RD, S_SCAN_CHK, S_DONE
    } t_state;

    localparam int PROD_W = oahi_pkg::SIZE_W + oahi_pkg::FILL_W;

    t_state                        r_state;
    logic                          r_bank;
    logic                          r_cbank;
    logic                          r_pbank;
    logic                          r_rehash;
    logic [oahi_pkg::SLOT_W-1:0]   r_ccnt;
    logic [oahi_pkg::SIZE_W-1:0]   r_size;
    logic [oahi_pkg::SIZE_W-1:0]   r_psize;
    logic [oahi_pkg::SIZE_W-1:0]   r_occ;
    logic [oahi_pkg::SIZE_W-1:0]   r_j;
    logic [oahi_pkg::HASH_W-1:0]   r_h;
    logic [oahi_pkg::HASH_W-1:0]   r_x;
    logic [oahi_pkg::SLOT_W-1:0]   r_s;
    logic [oahi_pkg::PROBE_W-1:0]  r_n;
    logic [oahi_pkg::COLL_W-1:0]   r_res_coll;
    logic [oahi_pkg::SLOT_W-1:0]   r_res_slot;
    logic                          r_res_grew;
    logic                          r_res_full;
    logic                          r_ovalid;
    logic [oahi_pkg::COLL_W-1:0]   r_ocoll;
    logic [oahi_pkg::SLOT_W-1:0]   r_oslot;
    logic                          r_ogrew;
    logic                          r_ofull;

    logic                          ram_we;
    logic [oahi_pkg::BANK_AW-1:0]  ram_waddr;
    logic [oahi_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [oahi_pkg::BANK_AW-1:0]  ram_raddr;
    logic [oahi_pkg::ENTRY_W-1:0]  ram_rdata;
    logic                          rd_used;
    logic [oahi_pkg::HASH_W-1:0]   rd_hash;

    logic                          div_start;
    logic [oahi_pkg::HASH_W-1:0]   div_dividend;
    logic [oahi_pkg::SIZE_W-1:0]   div_divisor;
    logic                          div_done;
    logic [oahi_pkg::SIZE_W-1:0]   div_rem;

    logic [oahi_pkg::SIZE_W-1:0]   size_dbl;
    logic [oahi_pkg::SLOT_W-1:0]   s_inc;
    logic [oahi_pkg::SLOT_W-1:0]   s_dec;
    logic [oahi_pkg::SIZE_W-1:0]   psize_m1;
    logic                          probe_last;
    logic [PROD_W-1:0]             fill_lhs;
    logic [PROD_W-1:0]             fill_rhs;
    logic                          over_fill;
    logic                          can_grow;
    logic                          out_free;
    logic [oahi_pkg::COLL_W-1:0]   coll_sat;
    logic                          start_ins;

    assign rd_used = ram_rdata[oahi_pkg::HASH_W];
    assign rd_hash = ram_rdata[oahi_pkg::HASH_W-1:0];

    assign size_dbl   = {r_size[oahi_pkg::SIZE_W-2:0], 1'b0};
    assign psize_m1   = r_psize - oahi_pkg::SIZE_W'(1);
    assign s_inc      = (({1'b0, r_s} + oahi_pkg::SIZE_W'(1)) == r_psize)
                      ? '0 : r_s + oahi_pkg::SLOT_W'(1);
    assign s_dec      = (r_s == '0) ? psize_m1[oahi_pkg::SLOT_W-1:0]
                      : r_s - oahi_pkg::SLOT_W'(1);
    assign probe_last = ((r_n + oahi_pkg::PROBE_W'(1)) == {r_psize, 1'b0});
    assign fill_lhs   = {r_occ, {oahi_pkg::FILL_W{1'b0}}};
    assign fill_rhs   = PROD_W'(i_cfg.max_fill) * PROD_W'(r_size);
    assign over_fill  = (fill_lhs > fill_rhs);
    assign can_grow   = ({r_size, 1'b0} <= oahi_pkg::PROBE_W'(oahi_pkg::TABLE_DEPTH));
    assign out_free   = !r_ovalid || i_ready;
    assign coll_sat   = (r_n > oahi_pkg::PROBE_W'(oahi_pkg::COLL_MAX))
                      ? oahi_pkg::COLL_MAX : r_n[oahi_pkg::COLL_W-1:0];

    assign start_ins = (r_state == S_IDLE) && !i_cfg.reinit && !i_q_empty;
    assign o_q_pop   = start_ins;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {r_pbank, r_s};
        ram_wdata = {1'b1, r_h};
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = {r_cbank, r_ccnt};
            ram_wdata = '0;
        end else if (r_state == S_CHK && !rd_used) begin
            ram_we = 1'b1;
        end
        ram_raddr = (r_state == S_SCAN_RD) ? {r_bank, r_j[oahi_pkg::SLOT_W-1:0]}
                                           : {r_pbank, r_s};
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = oahi_pkg::magnitude(i_q_data);
        div_divisor  = r_size;
        if (r_state == S_SCAN_CHK) begin
            div_start    = !i_cfg.reinit && rd_used;
            div_dividend = oahi_pkg::magnitude(rd_hash);
            div_divisor  = size_dbl;
        end else if (start_ins) begin
            div_start = (r_occ < r_size);
        end
    end

    oahi_ram #(
        .WIDTH (oahi_pkg::ENTRY_W),
        .DEPTH (2 * oahi_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    oahi_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_bank   <= 1'b0;
            r_cbank  <= 1'b0;
            r_ccnt   <= '0;
            r_rehash <= 1'b0;
            r_size   <= oahi_pkg::RESET_SLOTS;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
                r_ocoll  <= r_res_coll;
                r_oslot  <= r_res_slot;
                r_ogrew  <= r_res_grew;
                r_ofull  <= r_res_full;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end

            if (i_cfg.reinit) begin
                r_state  <= S_CLR;
                r_bank   <= 1'b0;
                r_cbank  <= 1'b0;
                r_ccnt   <= '0;
                r_rehash <= 1'b0;
                r_size   <= i_cfg.init_slots;
                r_occ    <= '0;
            end else begin
                unique case (r_state)
                    S_CLR: begin
                        r_ccnt <= r_ccnt + oahi_pkg::SLOT_W'(1);
                        if (r_ccnt == oahi_pkg::SLOT_W'(oahi_pkg::TABLE_DEPTH - 1)) begin
                            r_j     <= '0;
                            r_state <= r_rehash ? S_SCAN_RD : S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (start_ins) begin
                            r_h     <= i_q_data;
                            r_x     <= i_q_data;
                            r_n     <= '0;
                            r_psize <= r_size;
                            r_pbank <= r_bank;
                            if (r_occ >= r_size) begin
                                r_res_coll <= '0;
                                r_res_slot <= '0;
                                r_res_grew <= 1'b0;
                                r_res_full <= 1'b1;
                                r_state    <= S_DONE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                    end
                    S_DIV: begin
                        if (div_done) begin
                            r_s     <= div_rem[oahi_pkg::SLOT_W-1:0];
                            r_state <= S_RD;
                        end
                    end
                    S_RD: begin
                        r_state <= S_CHK;
                    end
                    S_CHK: begin
                        if (!rd_used) begin
                            if (r_rehash) begin
                                r_j     <= r_j + oahi_pkg::SIZE_W'(1);
                                r_state <= S_SCAN_RD;
                            end else begin
                                r_occ      <= r_occ + oahi_pkg::SIZE_W'(1);
                                r_res_coll <= coll_sat;
                                r_res_slot <= r_s;
                                r_res_grew <= 1'b0;
                                r_res_full <= 1'b0;
                                r_state    <= S_GCHK;
                            end
                        end else if (probe_last) begin
                            if (r_rehash) begin
                                r_j     <= r_j + oahi_pkg::SIZE_W'(1);
                                r_state <= S_SCAN_RD;
                            end else begin
                                r_res_coll <= '0;
                                r_res_slot <= '0;
                                r_res_grew <= 1'b0;
                                r_res_full <= 1'b1;
                                r_state    <= S_DONE;
                            end
                        end else begin
                            // magnitude falls while h+i is negative, rises otherwise
                            r_s     <= r_x[oahi_pkg::HASH_W-1] ? s_dec : s_inc;
                            r_x     <= r_x + oahi_pkg::HASH_W'(1);
                            r_n     <= r_n + oahi_pkg::PROBE_W'(1);
                            r_state <= S_RD;
                        end
                    end
                    S_GCHK: begin
                        if (over_fill && can_grow) begin
                            r_res_grew <= 1'b1;
                            r_rehash   <= 1'b1;
                            r_cbank    <= ~r_bank;
                            r_ccnt     <= '0;
                            r_state    <= S_CLR;
                        end else begin
                            r_res_full <= over_fill;
                            r_state    <= S_DONE;
                        end
                    end
                    S_SCAN_RD: begin
                        if (r_j == r_size) begin
                            r_bank   <= ~r_bank;
                            r_size   <= size_dbl;
                            r_rehash <= 1'b0;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN_CHK;
                        end
                    end
                    S_SCAN_CHK: begin
                        if (rd_used) begin
                            r_h     <= rd_hash;
                            r_x     <= rd_hash;
                            r_n     <= '0;
                            r_psize <= size_dbl;
                            r_pbank <= ~r_bank;
                            r_state <= S_DIV;
                        end else begin
                            r_j     <= r_j + oahi_pkg::SIZE_W'(1);
                            r_state <= S_SCAN_RD;
                        end
                    end
                    S_DONE: begin
                        if (out_free) begin
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_stat.clearing = (r_state == S_CLR) && !r_rehash;
    assign o_stat.growing  = r_rehash;

    assign o_valid           = r_ovalid;
    assign o_collision_count = r_ocoll;
    assign o_slot_index      = r_oslot;
    assign o_grew            = r_ogrew;
    assign o_full_flag       = r_ofull;

endmodule
